[rtl/assert_macros.svh]
// assertion macros included by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define CTSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define CTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CTSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define CTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/ctsc_pkg.sv]
// command codes, field widths and reset constants of the column texture scaler
package ctsc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD_TEXEL = 2'd0,
		CMD_LOAD_REMAP = 2'd1,
		CMD_START      = 2'd2,
		CMD_STEP       = 2'd3
	} cmd_t;

	localparam int COORD_W = 32;
	localparam int ADDR_W  = 14;
	localparam int PLANE_W = 4;
	localparam int ROW_W   = 8;
	localparam int COL_W   = 9;
	localparam int BYTE_W  = 8;
	localparam int DIV_CNT_W = 5;

	localparam logic [ROW_W-1:0] CENTER_ROW_RESET = 8'd100;

endpackage

[rtl/column_texture_scaler_core.sv]
// column texture scaler: texel and remap memories, start setup with modulo unit, pixel stepper
// pixel: a step transaction reads the texel memory, S_TEX reads the remap memory, and S_REM
//   loads the output register once it is free; in_stall holds off commands until then
// start: S_MUL, S_ADD; other heights add S_DIV (one remainder bit per cycle) and S_FIX
// loads: a finished pixel waits in the output register without blocking loads
// arst_n clears control state; center_row resets to 100; memories are not cleared
`include "assert_macros.svh"

module column_texture_scaler_core
	import ctsc_pkg::*;
#(
	parameter int TEX_DEPTH = 128,
	parameter int ROW_BYTES = 80,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [ROW_W-1:0]   cfg_write_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [BYTE_W-1:0]  table_index,
	input  logic [BYTE_W-1:0]  table_value,
	input  logic [COL_W-1:0]   column_x,
	input  logic [ROW_W-1:0]   top_row,
	input  logic [ROW_W-1:0]   bottom_row,
	input  logic [COORD_W-1:0] inv_scale,
	input  logic signed [COORD_W-1:0] texture_mid,
	input  logic [BYTE_W-1:0]  tex_height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ADDR_W-1:0]  pixel_address,
	output logic [PLANE_W-1:0] plane_mask,
	output logic [BYTE_W-1:0]  pixel_color,
	output logic               last_pixel
);

	localparam int TEX_AW = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
	localparam int PW = BYTE_W + FRAC_BITS;
	localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(ROW_BYTES % (1 << ADDR_W));
	localparam logic [BYTE_W:0] TEX_LIMIT = (BYTE_W+1)'(TEX_DEPTH);

	function automatic logic [255:0][BYTE_W-1:0] build_mod_tbl();
		logic [255:0][BYTE_W-1:0] t;
		for (int k = 0; k < 256; k++) begin
			t[k] = BYTE_W'(k % TEX_DEPTH);
		end
		return t;
	endfunction

	localparam logic [255:0][BYTE_W-1:0] MOD_TBL = build_mod_tbl();

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_DIV,
		S_FIX,
		S_TEX,
		S_REM
	} state_t;

	state_t state_q;

	logic [ROW_W-1:0]   center_row_q;
	logic [COORD_W-1:0] tex_coord_q;
	logic [COORD_W-1:0] step_value_q;
	logic [BYTE_W-1:0]  pixels_left_q;
	logic [ADDR_W-1:0]  cur_address_q;
	logic [PLANE_W-1:0] cur_plane_q;
	logic [BYTE_W-1:0]  wrap_height_q;
	logic               pow2_height_q;

	logic [COORD_W-1:0] mid_q;
	logic [ROW_W:0]     diff_q;
	logic [COORD_W-1:0] product_q;
	logic               neg_q;
	logic [COORD_W-1:0] mag_q;
	logic [PW-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [ADDR_W-1:0]  addr_s1;
	logic [PLANE_W-1:0] plane_s1;
	logic               last_s1;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  pixel_address_q;
	logic [PLANE_W-1:0] plane_mask_q;
	logic [BYTE_W-1:0]  pixel_color_q;
	logic               last_pixel_q;

	logic [BYTE_W-1:0]  texel_mem [TEX_DEPTH];
	logic [BYTE_W-1:0]  remap_mem [256];
	logic [BYTE_W-1:0]  texel_rd_q;
	logic [BYTE_W-1:0]  remap_rd_q;

	logic               accept;
	cmd_t               cmd;
	logic               step_go;
	logic               tex_we;
	logic               remap_we;
	logic [TEX_AW-1:0]  tex_raddr;
	logic [BYTE_W-1:0]  idx_raw;
	logic [BYTE_W-1:0]  idx_masked;
	logic [PW-1:0]      period;
	logic [COORD_W-1:0] step_sum;
	logic [COORD_W-1:0] step_next;
	logic [ROW_W:0]     count_raw;
	logic [BYTE_W-1:0]  count_sat;
	logic [ADDR_W-1:0]  start_addr;
	logic [COORD_W-1:0] diff_ext;
	logic [COORD_W-1:0] frac_sum;
	logic [PW:0]        rem_sh;
	logic [PW-1:0]      rem_nx;
	logic [PW-1:0]      rem_fixed;
	logic               out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cmd      = cmd_t'(command);
	assign step_go  = accept && (cmd == CMD_STEP) && (pixels_left_q != '0);
	assign tex_we   = accept && (cmd == CMD_LOAD_TEXEL) && ({1'b0, table_index} < TEX_LIMIT);
	assign remap_we = accept && (cmd == CMD_LOAD_REMAP);
	assign out_free = !out_valid_q || !out_stall;

	assign period = {wrap_height_q, {FRAC_BITS{1'b0}}};

	// texel index: integer part, mask for power-of-two heights, then fold into the store
	assign idx_raw    = tex_coord_q[FRAC_BITS +: BYTE_W];
	assign idx_masked = pow2_height_q ? (idx_raw & (wrap_height_q - 8'd1)) : idx_raw;
	assign tex_raddr  = MOD_TBL[idx_masked][TEX_AW-1:0];

	// advance with a single wrap subtraction
	always_comb begin
		step_sum  = tex_coord_q + step_value_q;
		step_next = step_sum;
		if (!pow2_height_q && !step_sum[COORD_W-1] && (step_sum >= COORD_W'(period))) begin
			step_next = step_sum - COORD_W'(period);
		end
	end

	// start column setup
	always_comb begin
		count_raw  = {1'b0, bottom_row} - {1'b0, top_row} + 9'd1;
		if (bottom_row < top_row) begin
			count_sat = '0;
		end else if (count_raw[ROW_W]) begin
			count_sat = 8'hFF;
		end else begin
			count_sat = count_raw[BYTE_W-1:0];
		end
		start_addr = ADDR_W'(top_row) * ROW_STEP + ADDR_W'(column_x[COL_W-1:2]);
		diff_ext   = COORD_W'(signed'(diff_q));
		frac_sum   = mid_q + product_q;
	end

	// one remainder bit per cycle on the magnitude
	always_comb begin
		rem_sh = {rem_q, mag_q[COORD_W-1]};
		if (rem_sh >= {1'b0, period}) begin
			rem_nx = PW'(rem_sh - {1'b0, period});
		end else begin
			rem_nx = rem_sh[PW-1:0];
		end
		rem_fixed = (neg_q && (rem_q != '0)) ? (period - rem_q) : rem_q;
	end

	always_ff @(posedge clk) begin
		if (tex_we) begin
			texel_mem[table_index[TEX_AW-1:0]] <= table_value;
		end
		if (step_go) begin
			texel_rd_q <= texel_mem[tex_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (remap_we) begin
			remap_mem[table_index] <= table_value;
		end
		if (state_q == S_TEX) begin
			remap_rd_q <= remap_mem[texel_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			center_row_q    <= CENTER_ROW_RESET;
			tex_coord_q     <= '0;
			step_value_q    <= '0;
			pixels_left_q   <= '0;
			cur_address_q   <= '0;
			cur_plane_q     <= '0;
			wrap_height_q   <= 8'd1;
			pow2_height_q   <= 1'b1;
			mid_q           <= '0;
			diff_q          <= '0;
			product_q       <= '0;
			neg_q           <= 1'b0;
			mag_q           <= '0;
			rem_q           <= '0;
			div_cnt_q       <= '0;
			addr_s1         <= '0;
			plane_s1        <= '0;
			last_s1         <= 1'b0;
			out_valid_q     <= 1'b0;
			pixel_address_q <= '0;
			plane_mask_q    <= '0;
			pixel_color_q   <= '0;
			last_pixel_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				center_row_q <= cfg_write_data;
			end
			// in S_REM the output register is reloaded below instead
			if (out_valid_q && !out_stall && (state_q != S_REM)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (cmd == CMD_START)) begin
						pixels_left_q <= count_sat;
						cur_address_q <= start_addr;
						cur_plane_q   <= PLANE_W'(1) << column_x[1:0];
						step_value_q  <= inv_scale;
						wrap_height_q <= tex_height;
						pow2_height_q <= ((tex_height & (tex_height - 8'd1)) == 8'd0);
						mid_q         <= texture_mid;
						diff_q        <= {1'b0, top_row} - {1'b0, center_row_q};
						state_q       <= S_MUL;
					end else if (step_go) begin
						addr_s1       <= cur_address_q;
						plane_s1      <= cur_plane_q;
						last_s1       <= (pixels_left_q == 8'd1);
						tex_coord_q   <= step_next;
						cur_address_q <= cur_address_q + ROW_STEP;
						pixels_left_q <= pixels_left_q - 8'd1;
						state_q       <= S_TEX;
					end
				end
				S_MUL: begin
					product_q <= diff_ext * step_value_q;
					state_q   <= S_ADD;
				end
				S_ADD: begin
					if (pow2_height_q) begin
						tex_coord_q <= frac_sum;
						state_q     <= S_IDLE;
					end else begin
						neg_q     <= frac_sum[COORD_W-1];
						mag_q     <= frac_sum[COORD_W-1] ? (~frac_sum + 32'd1) : frac_sum;
						rem_q     <= '0;
						div_cnt_q <= DIV_CNT_W'(COORD_W - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					mag_q <= {mag_q[COORD_W-2:0], 1'b0};
					if (div_cnt_q == '0) begin
						state_q <= S_FIX;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				S_FIX: begin
					tex_coord_q <= COORD_W'(rem_fixed);
					state_q     <= S_IDLE;
				end
				S_TEX: begin
					state_q <= S_REM;
				end
				S_REM: begin
					// hold the remap data until the output register frees up
					if (out_free) begin
						out_valid_q     <= 1'b1;
						pixel_address_q <= addr_s1;
						plane_mask_q    <= plane_s1;
						pixel_color_q   <= remap_rd_q;
						last_pixel_q    <= last_s1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = pixel_address_q;
	assign plane_mask    = plane_mask_q;
	assign pixel_color   = pixel_color_q;
	assign last_pixel    = last_pixel_q;

	`CTSC_ASSERT_NEXT(a_pixel_count_dec, clk, arst_n, step_go, pixels_left_q == $past(pixels_left_q) - 8'd1)
	`CTSC_ASSERT_NEXT(a_mod_in_range, clk, arst_n, state_q == S_FIX, tex_coord_q < COORD_W'(period))
	`CTSC_ASSERT_ALWAYS(a_out_from_remap, clk, arst_n, !$rose(out_valid_q) || $past(state_q == S_REM))

endmodule
